// ===== rtl/lru_set_associative_cache_model_defines.svh =====
// assertion macros for the lru set-associative cache model
// used by the top level; expects clk_i and rst_ni in scope
`ifndef LRU_SET_ASSOCIATIVE_CACHE_MODEL_DEFINES_SVH
`define LRU_SET_ASSOCIATIVE_CACHE_MODEL_DEFINES_SVH

// consequent checked in the same cycle
`define LRUSAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LRUSAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lrusac_pkg.sv =====
// shared types and constants of the lru set-associative cache model
// no dependencies
package lrusac_pkg;

  localparam int DEF_MAX_SETS = 64;
  localparam int DEF_MAX_WAYS = 8;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 62;
  localparam int CNT_W   = 32;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int BB_MAX  = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS  = 2'd2;

  typedef enum logic [1:0] {
    OP_FETCH  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_STORE  = 2'd2,
    OP_MODIFY = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] address;
  } access_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic             last;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } result_t;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [3:0] ways_in_use;
    logic [5:0] block_bits;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic meta_we;
    logic tag_we;
  } mem_ctl_t;

endpackage

// ===== rtl/lru_set_associative_cache_model.sv =====
// top level of the lru set-associative cache model
// depends on lrusac_pkg, lrusac_cfg_regs, lrusac_line_store, lrusac_seq
// and lru_set_associative_cache_model_defines.svh
//
//   port group   direction  handshake              word
//   in           in         in_valid_i/in_stall_o  access_t: op, address
//   out          out        out_valid_o/out_stall_i result_t: hit, evicted, last, totals
//   apb          in/out     psel/penable/pready    set_bits, ways_in_use, block_bits
//
// a fetch is taken in idle and gives no result; a load or store gives one result, a modify two
// a lookup makes two passes over the ways of the set, one line memory read per cycle
// after reset a clearing pass writes all 2^(log2 sets + log2 ways) lines (512 by default)
// of the valid and rank memory while in_stall_o is high
// a result waiting on out_stall_i holds the sequencer before its output step
`include "lru_set_associative_cache_model_defines.svh"

module lru_set_associative_cache_model #(
  parameter int MAX_SETS = lrusac_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = lrusac_pkg::DEF_MAX_WAYS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lrusac_pkg::access_t            in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lrusac_pkg::result_t            out_word_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lrusac_pkg::PADDR_W-1:0] paddr,
  input  logic [lrusac_pkg::PDATA_W-1:0] pwdata,
  output logic [lrusac_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int SIW = $clog2(MAX_SETS + 1) - 1;
  localparam int WW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RW  = WW;
  localparam int LAW = SIW + WW;

  lrusac_pkg::cfg_t              cfg;
  lrusac_pkg::mem_ctl_t          mem_ctl;
  logic [LAW-1:0]                rd_addr;
  logic [LAW-1:0]                wr_addr;
  logic                          wr_valid;
  logic [RW-1:0]                 wr_rank;
  logic [lrusac_pkg::TAG_W-1:0]  wr_tag;
  logic                          rd_valid;
  logic [RW-1:0]                 rd_rank;
  logic [lrusac_pkg::TAG_W-1:0]  rd_tag;

  lrusac_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lrusac_line_store #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_store (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_valid_i (wr_valid),
    .wr_rank_i  (wr_rank),
    .wr_tag_i   (wr_tag),
    .rd_valid_o (rd_valid),
    .rd_rank_o  (rd_rank),
    .rd_tag_o   (rd_tag)
  );

  lrusac_seq #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .ctl_o       (mem_ctl),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wr_valid_o  (wr_valid),
    .wr_rank_o   (wr_rank),
    .wr_tag_o    (wr_tag),
    .rd_valid_i  (rd_valid),
    .rd_rank_i   (rd_rank),
    .rd_tag_i    (rd_tag)
  );

  `LRUSAC_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o && in_word_i.op != lrusac_pkg::OP_FETCH, in_stall_o, "lookup did not hold off the next word")
  `LRUSAC_ASSERT_SAME(a_modify_pending, out_valid_o && !out_word_o.last, in_stall_o, "input open while a modify is unfinished")
  `LRUSAC_ASSERT_SAME(a_evict_on_miss, out_valid_o && out_word_o.evicted, !out_word_o.hit, "eviction reported on a hit")

endmodule

// ===== rtl/lrusac_cfg_regs.sv =====
// apb configuration registers of the lru cache model
// depends on lrusac_pkg
module lrusac_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrusac_pkg::PADDR_W-1:0] paddr,
  input  logic [lrusac_pkg::PDATA_W-1:0] pwdata,
  output logic [lrusac_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output lrusac_pkg::cfg_t              cfg_o
);

  lrusac_pkg::cfg_t cfg_q, cfg_d;
  logic             wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        lrusac_pkg::REG_SET_BITS:    cfg_d.set_bits    = pwdata[2:0];
        lrusac_pkg::REG_WAYS_IN_USE: cfg_d.ways_in_use = pwdata[3:0];
        lrusac_pkg::REG_BLOCK_BITS:  cfg_d.block_bits  = pwdata[5:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lrusac_pkg::REG_SET_BITS:    prdata = {29'd0, cfg_q.set_bits};
      lrusac_pkg::REG_WAYS_IN_USE: prdata = {28'd0, cfg_q.ways_in_use};
      lrusac_pkg::REG_BLOCK_BITS:  prdata = {26'd0, cfg_q.block_bits};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits    <= 3'd1;
      cfg_q.ways_in_use <= 4'd1;
      cfg_q.block_bits  <= 6'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/lrusac_line_store.sv =====
// line memories: valid and rank per line, tag per line
// depends on lrusac_pkg; one write and one registered read per cycle
module lrusac_line_store #(
  parameter int MAX_SETS = lrusac_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = lrusac_pkg::DEF_MAX_WAYS,
  localparam int SIW     = $clog2(MAX_SETS + 1) - 1,
  localparam int WW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int RW      = WW,
  localparam int LAW     = SIW + WW
) (
  input  logic                          clk_i,
  input  lrusac_pkg::mem_ctl_t          ctl_i,
  input  logic [LAW-1:0]                rd_addr_i,
  input  logic [LAW-1:0]                wr_addr_i,
  input  logic                          wr_valid_i,
  input  logic [RW-1:0]                 wr_rank_i,
  input  logic [lrusac_pkg::TAG_W-1:0]  wr_tag_i,
  output logic                          rd_valid_o,
  output logic [RW-1:0]                 rd_rank_o,
  output logic [lrusac_pkg::TAG_W-1:0]  rd_tag_o
);

  localparam int NLINES = 1 << LAW;

  logic [RW:0]                    meta_mem [NLINES];
  logic [lrusac_pkg::TAG_W-1:0]   tag_mem  [NLINES];
  logic [RW:0]                    rd_meta_q;
  logic [lrusac_pkg::TAG_W-1:0]   rd_tag_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.meta_we) begin
      meta_mem[wr_addr_i] <= {wr_valid_i, wr_rank_i};
    end
    if (ctl_i.rd_en) begin
      rd_meta_q <= meta_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.tag_we) begin
      tag_mem[wr_addr_i] <= wr_tag_i;
    end
    if (ctl_i.rd_en) begin
      rd_tag_q <= tag_mem[rd_addr_i];
    end
  end

  assign rd_valid_o = rd_meta_q[RW];
  assign rd_rank_o  = rd_meta_q[RW-1:0];
  assign rd_tag_o   = rd_tag_q;

endmodule

// ===== rtl/lrusac_seq.sv =====
// lookup sequencer: walks the ways of a set through one compare unit,
// then rewrites ranks way by way; holds counters and the output register
// depends on lrusac_pkg
module lrusac_seq #(
  parameter int MAX_SETS = lrusac_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = lrusac_pkg::DEF_MAX_WAYS,
  localparam int SIW     = $clog2(MAX_SETS + 1) - 1,
  localparam int WW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int RW      = WW,
  localparam int LAW     = SIW + WW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lrusac_pkg::cfg_t              cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lrusac_pkg::access_t           in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lrusac_pkg::result_t           out_word_o,
  output lrusac_pkg::mem_ctl_t          ctl_o,
  output logic [LAW-1:0]                rd_addr_o,
  output logic [LAW-1:0]                wr_addr_o,
  output logic                          wr_valid_o,
  output logic [RW-1:0]                 wr_rank_o,
  output logic [lrusac_pkg::TAG_W-1:0]  wr_tag_o,
  input  logic                          rd_valid_i,
  input  logic [RW-1:0]                 rd_rank_i,
  input  logic [lrusac_pkg::TAG_W-1:0]  rd_tag_i
);

  localparam int WCW  = $clog2(MAX_WAYS + 1);
  localparam int RMAX = MAX_WAYS - 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_UPDATE,
    ST_UPDATE_END,
    ST_EMIT,
    ST_EMIT2
  } state_e;

  state_e                         state_q, state_d;
  logic [LAW-1:0]                 clr_q, clr_d;
  logic                           modify_q, modify_d;
  logic [lrusac_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [SIW-1:0]                 set_q, set_d;
  logic [lrusac_pkg::TAG_W-1:0]   tag_q, tag_d;
  logic [WW-1:0]                  way_q, way_d;
  logic                           pend_q, pend_d;
  logic [WW-1:0]                  pend_way_q, pend_way_d;
  logic                           hit_found_q, hit_found_d;
  logic [WW-1:0]                  hit_way_q, hit_way_d;
  logic [RW-1:0]                  hit_rank_q, hit_rank_d;
  logic                           inv_found_q, inv_found_d;
  logic [WW-1:0]                  inv_way_q, inv_way_d;
  logic [WW-1:0]                  vic_way_q, vic_way_d;
  logic [RW-1:0]                  vic_rank_q, vic_rank_d;
  logic [WW-1:0]                  tgt_way_q, tgt_way_d;
  logic [RW-1:0]                  old_q, old_d;
  logic                           old_inf_q, old_inf_d;
  logic                           res_hit_q, res_hit_d;
  logic                           res_ev_q, res_ev_d;
  logic [lrusac_pkg::CNT_W-1:0]   hit_cnt_q, hit_cnt_d;
  logic [lrusac_pkg::CNT_W-1:0]   miss_cnt_q, miss_cnt_d;
  logic [lrusac_pkg::CNT_W-1:0]   ev_cnt_q, ev_cnt_d;
  logic                           out_valid_q, out_valid_d;
  lrusac_pkg::result_t            out_word_q, out_word_d;

  logic [2:0]                     sb_eff;
  logic [5:0]                     bb_eff;
  logic [WCW-1:0]                 ways_eff;
  logic [WW-1:0]                  last_way;
  logic [6:0]                     tag_shift;
  logic [lrusac_pkg::ADDR_W-1:0]  set_shifted;
  logic                           out_free;
  logic                           bump;

  // register saturation
  always_comb begin
    if (cfg_i.set_bits == 3'd0) begin
      sb_eff = 3'd1;
    end else if (int'(cfg_i.set_bits) > SIW) begin
      sb_eff = 3'(SIW);
    end else begin
      sb_eff = cfg_i.set_bits;
    end
    if (cfg_i.block_bits == 6'd0) begin
      bb_eff = 6'd1;
    end else if (int'(cfg_i.block_bits) > lrusac_pkg::BB_MAX) begin
      bb_eff = 6'(lrusac_pkg::BB_MAX);
    end else begin
      bb_eff = cfg_i.block_bits;
    end
    if (cfg_i.ways_in_use == 4'd0) begin
      ways_eff = WCW'(1);
    end else if (int'(cfg_i.ways_in_use) > MAX_WAYS) begin
      ways_eff = WCW'(MAX_WAYS);
    end else begin
      ways_eff = WCW'(cfg_i.ways_in_use);
    end
  end

  assign last_way    = WW'(ways_eff - WCW'(1));
  assign tag_shift   = {1'b0, bb_eff} + {4'd0, sb_eff};
  assign set_shifted = addr_q >> bb_eff;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign bump        = rd_valid_i && (old_inf_q || rd_rank_i < old_q) &&
                       rd_rank_i < RW'(RMAX);

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign wr_tag_o    = tag_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    modify_d    = modify_q;
    addr_d      = addr_q;
    set_d       = set_q;
    tag_d       = tag_q;
    way_d       = way_q;
    pend_d      = 1'b0;
    pend_way_d  = pend_way_q;
    hit_found_d = hit_found_q;
    hit_way_d   = hit_way_q;
    hit_rank_d  = hit_rank_q;
    inv_found_d = inv_found_q;
    inv_way_d   = inv_way_q;
    vic_way_d   = vic_way_q;
    vic_rank_d  = vic_rank_q;
    tgt_way_d   = tgt_way_q;
    old_d       = old_q;
    old_inf_d   = old_inf_q;
    res_hit_d   = res_hit_q;
    res_ev_d    = res_ev_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    ev_cnt_d    = ev_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    ctl_o       = '0;
    rd_addr_o   = {set_q, way_q};
    wr_addr_o   = {set_q, pend_way_q};
    wr_valid_o  = 1'b0;
    wr_rank_o   = '0;

    // compare unit on the line read last cycle
    if (pend_q && (state_q == ST_SCAN || state_q == ST_SCAN_END)) begin
      if (rd_valid_i && rd_tag_i == tag_q && !hit_found_q) begin
        hit_found_d = 1'b1;
        hit_way_d   = pend_way_q;
        hit_rank_d  = rd_rank_i;
      end
      if (!rd_valid_i && !inv_found_q) begin
        inv_found_d = 1'b1;
        inv_way_d   = pend_way_q;
      end
      if (pend_way_q == '0 || rd_rank_i > vic_rank_q) begin
        vic_way_d  = pend_way_q;
        vic_rank_d = rd_rank_i;
      end
    end

    // rank rewrite of the line read last cycle
    if (pend_q && (state_q == ST_UPDATE || state_q == ST_UPDATE_END)) begin
      ctl_o.meta_we = 1'b1;
      if (pend_way_q == tgt_way_q) begin
        ctl_o.tag_we = 1'b1;
        wr_valid_o   = 1'b1;
        wr_rank_o    = '0;
      end else begin
        wr_valid_o = rd_valid_i;
        wr_rank_o  = rd_rank_i + RW'(bump);
      end
    end

    case (state_q)
      ST_CLEAR: begin
        ctl_o.meta_we = 1'b1;
        wr_addr_o     = clr_q;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + LAW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i && in_word_i.op != lrusac_pkg::OP_FETCH) begin
          addr_d   = in_word_i.address;
          modify_d = in_word_i.op == lrusac_pkg::OP_MODIFY;
          state_d  = ST_PREP;
        end
      end
      ST_PREP: begin
        set_d       = set_shifted[SIW-1:0] & ~({SIW{1'b1}} << sb_eff);
        tag_d       = lrusac_pkg::TAG_W'(addr_q >> tag_shift);
        hit_found_d = 1'b0;
        inv_found_d = 1'b0;
        way_d       = '0;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        ctl_o.rd_en = 1'b1;
        pend_d      = 1'b1;
        pend_way_d  = way_q;
        if (way_q == last_way) begin
          state_d = ST_SCAN_END;
        end else begin
          way_d = way_q + WW'(1);
        end
      end
      ST_SCAN_END: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        way_d   = '0;
        state_d = ST_UPDATE;
        if (hit_found_q) begin
          tgt_way_d = hit_way_q;
          old_d     = hit_rank_q;
          old_inf_d = 1'b0;
          res_hit_d = 1'b1;
          res_ev_d  = 1'b0;
          hit_cnt_d = hit_cnt_q + 32'd1;
        end else if (inv_found_q) begin
          tgt_way_d  = inv_way_q;
          old_d      = '0;
          old_inf_d  = 1'b1;
          res_hit_d  = 1'b0;
          res_ev_d   = 1'b0;
          miss_cnt_d = miss_cnt_q + 32'd1;
        end else begin
          tgt_way_d  = vic_way_q;
          old_d      = vic_rank_q;
          old_inf_d  = 1'b0;
          res_hit_d  = 1'b0;
          res_ev_d   = 1'b1;
          miss_cnt_d = miss_cnt_q + 32'd1;
          ev_cnt_d   = ev_cnt_q + 32'd1;
        end
      end
      ST_UPDATE: begin
        ctl_o.rd_en = 1'b1;
        pend_d      = 1'b1;
        pend_way_d  = way_q;
        if (way_q == last_way) begin
          state_d = ST_UPDATE_END;
        end else begin
          way_d = way_q + WW'(1);
        end
      end
      ST_UPDATE_END: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_word_d.hit             = res_hit_q;
          out_word_d.evicted         = res_ev_q;
          out_word_d.last            = !modify_q;
          out_word_d.hit_total       = hit_cnt_q;
          out_word_d.miss_total      = miss_cnt_q;
          out_word_d.eviction_total  = ev_cnt_q;
          state_d                    = modify_q ? ST_EMIT2 : ST_IDLE;
        end
      end
      ST_EMIT2: begin
        // the store half of a modify hits the line just touched
        if (out_free) begin
          hit_cnt_d                  = hit_cnt_q + 32'd1;
          out_valid_d                = 1'b1;
          out_word_d.hit             = 1'b1;
          out_word_d.evicted         = 1'b0;
          out_word_d.last            = 1'b1;
          out_word_d.hit_total       = hit_cnt_q + 32'd1;
          out_word_d.miss_total      = miss_cnt_q;
          out_word_d.eviction_total  = ev_cnt_q;
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      modify_q    <= 1'b0;
      addr_q      <= '0;
      set_q       <= '0;
      tag_q       <= '0;
      way_q       <= '0;
      pend_q      <= 1'b0;
      pend_way_q  <= '0;
      hit_found_q <= 1'b0;
      hit_way_q   <= '0;
      hit_rank_q  <= '0;
      inv_found_q <= 1'b0;
      inv_way_q   <= '0;
      vic_way_q   <= '0;
      vic_rank_q  <= '0;
      tgt_way_q   <= '0;
      old_q       <= '0;
      old_inf_q   <= 1'b0;
      res_hit_q   <= 1'b0;
      res_ev_q    <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      ev_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      modify_q    <= modify_d;
      addr_q      <= addr_d;
      set_q       <= set_d;
      tag_q       <= tag_d;
      way_q       <= way_d;
      pend_q      <= pend_d;
      pend_way_q  <= pend_way_d;
      hit_found_q <= hit_found_d;
      hit_way_q   <= hit_way_d;
      hit_rank_q  <= hit_rank_d;
      inv_found_q <= inv_found_d;
      inv_way_q   <= inv_way_d;
      vic_way_q   <= vic_way_d;
      vic_rank_q  <= vic_rank_d;
      tgt_way_q   <= tgt_way_d;
      old_q       <= old_d;
      old_inf_q   <= old_inf_d;
      res_hit_q   <= res_hit_d;
      res_ev_q    <= res_ev_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      ev_cnt_q    <= ev_cnt_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for lru_set_associative_cache_model: accesses are scored
// against an in-bench lru cache predictor, registers are set over apb between phases
// depends on lrusac_pkg and the rtl top level
module testbench;
  import lrusac_pkg::*;

  localparam int LINES         = DEF_MAX_SETS * DEF_MAX_WAYS;
  localparam int SET_BITS_MAX  = $clog2(DEF_MAX_SETS);
  localparam int ITEM_TARGET   = 1350;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;

  typedef enum bit {ROW_ACCESS, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [1:0]          reg_idx;
    logic [PDATA_W-1:0]  reg_value;
    access_t             word;
    bit                  typed;
    result_t             expected;
  } stim_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  access_t            in_word_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  result_t            out_word_o;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // predictor state
  logic [TAG_W-1:0] line_tags [LINES];
  bit               line_live [LINES];
  logic [2:0]       line_age  [LINES];
  logic [CNT_W-1:0] hits_so_far;
  logic [CNT_W-1:0] misses_so_far;
  logic [CNT_W-1:0] evictions_so_far;
  logic [2:0]       set_bits_reg;
  logic [3:0]       ways_reg;
  logic [5:0]       block_bits_reg;
  result_t          pending_results [$];

  int mismatches    = 0;
  int accesses_done = 0;
  int idle_cycles   = 0;
  int stall_left    = 0;
  int gap_odds      = 4;
  int stall_odds    = 6;
  bit calm_tail     = 1'b0;

  lru_set_associative_cache_model uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int used_set_bits();
    int s;
    s = set_bits_reg;
    if (s < 1) s = 1;
    if (s > SET_BITS_MAX) s = SET_BITS_MAX;
    return s;
  endfunction

  function automatic int used_ways();
    int w;
    w = ways_reg;
    if (w < 1) w = 1;
    if (w > DEF_MAX_WAYS) w = DEF_MAX_WAYS;
    return w;
  endfunction

  function automatic int used_block_bits();
    int b;
    b = block_bits_reg;
    if (b < 1) b = 1;
    if (b > BB_MAX) b = BB_MAX;
    return b;
  endfunction

  // make way w the most recent, aging the valid ways younger than it was
  function automatic void refresh_age(int base, int ways, int w, int old_age);
    for (int i = 0; i < ways; i++) begin
      if (i != w && line_live[base + i] && line_age[base + i] < old_age &&
          line_age[base + i] < DEF_MAX_WAYS - 1) begin
        line_age[base + i]++;
      end
    end
    line_age[base + w] = '0;
  endfunction

  function automatic result_t cache_lookup(input logic [ADDR_W-1:0] address, input bit last);
    int sb, bb, ways, set_idx, base, victim;
    logic [TAG_W-1:0] tag;
    result_t res;
    sb = used_set_bits();
    bb = used_block_bits();
    ways = used_ways();
    set_idx = int'((address >> bb) & ((64'd1 << sb) - 64'd1));
    tag = TAG_W'(address >> (bb + sb));
    base = set_idx * DEF_MAX_WAYS;
    res = '0;
    res.last = last;
    victim = -1;
    for (int i = 0; i < ways; i++) begin
      if (victim < 0 && line_live[base + i] && line_tags[base + i] == tag) victim = i;
    end
    if (victim >= 0) begin
      refresh_age(base, ways, victim, line_age[base + victim]);
      hits_so_far++;
      res.hit = 1'b1;
    end else begin
      misses_so_far++;
      for (int i = 0; i < ways; i++) begin
        if (victim < 0 && !line_live[base + i]) victim = i;
      end
      if (victim < 0) begin
        victim = 0;
        for (int i = 1; i < ways; i++) begin
          if (line_age[base + i] > line_age[base + victim]) victim = i;
        end
        evictions_so_far++;
        res.evicted = 1'b1;
        refresh_age(base, ways, victim, line_age[base + victim]);
      end else begin
        refresh_age(base, ways, victim, DEF_MAX_WAYS);
      end
      line_live[base + victim] = 1'b1;
      line_tags[base + victim] = tag;
    end
    res.hit_total      = hits_so_far;
    res.miss_total     = misses_so_far;
    res.eviction_total = evictions_so_far;
    return res;
  endfunction

  function automatic void predict_access(input access_t w);
    if (w.op == OP_FETCH) return;
    pending_results.push_back(cache_lookup(w.address, w.op != OP_MODIFY));
    if (w.op == OP_MODIFY) pending_results.push_back(cache_lookup(w.address, 1'b1));
  endfunction

  function automatic stim_row_t access_row(input op_e op, input logic [ADDR_W-1:0] address);
    stim_row_t row;
    row.kind = ROW_ACCESS;
    row.reg_idx = REG_SET_BITS;
    row.reg_value = '0;
    row.word.op = op;
    row.word.address = address;
    row.typed = 1'b0;
    row.expected = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input op_e op, input logic [ADDR_W-1:0] address,
                                          input bit hit, input bit evicted,
                                          input int hits, input int misses,
                                          input int evictions);
    stim_row_t row;
    row = access_row(op, address);
    row.typed = 1'b1;
    row.expected.hit = hit;
    row.expected.evicted = evicted;
    row.expected.last = 1'b1;
    row.expected.hit_total = hits;
    row.expected.miss_total = misses;
    row.expected.eviction_total = evictions;
    return row;
  endfunction

  function automatic stim_row_t config_row(input logic [1:0] idx, input int value);
    stim_row_t row;
    row = access_row(OP_FETCH, '0);
    row.kind = ROW_CONFIG;
    row.reg_idx = idx;
    row.reg_value = value;
    return row;
  endfunction

  task automatic send_access(input access_t w);
    if (gap_odds != 0 && !calm_tail && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_access(w);
    accesses_done++;
  endtask

  // drop valid, wait for every result, then let a trailing fetch finish
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic [1:0] idx, input logic wr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] keep_mask, wdata, readback;
    case (idx)
      REG_SET_BITS: begin
        keep_mask = 32'h7;
        set_bits_reg = value[2:0];
      end
      REG_WAYS_IN_USE: begin
        keep_mask = 32'hf;
        ways_reg = value[3:0];
      end
      default: begin
        keep_mask = 32'h3f;
        block_bits_reg = value[5:0];
      end
    endcase
    // junk above the field width must be ignored
    wdata = ($urandom & ~keep_mask) | (value & keep_mask);
    apb_access(idx, 1'b1, wdata, readback);
    apb_access(idx, 1'b0, '0, readback);
    if (((readback ^ value) & keep_mask) != 0) begin
      flag_mismatch("register readback", readback & keep_mask, value & keep_mask);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver stall bursts
  always @(posedge clk_i) begin
    int left;
    left = stall_left;
    if (left > 0) begin
      left--;
    end else if (!calm_tail && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      left = $urandom_range(1, 10);
    end
    stall_left <= left;
    out_stall_i <= (left > 0);
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result word with nothing expected", out_word_o.hit_total, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_word_o.hit !== want.hit) flag_mismatch("hit", out_word_o.hit, want.hit);
        if (out_word_o.evicted !== want.evicted) begin
          flag_mismatch("evicted", out_word_o.evicted, want.evicted);
        end
        if (out_word_o.last !== want.last) flag_mismatch("last", out_word_o.last, want.last);
        if (out_word_o.hit_total !== want.hit_total) begin
          flag_mismatch("hit_total", out_word_o.hit_total, want.hit_total);
        end
        if (out_word_o.miss_total !== want.miss_total) begin
          flag_mismatch("miss_total", out_word_o.miss_total, want.miss_total);
        end
        if (out_word_o.eviction_total !== want.eviction_total) begin
          flag_mismatch("eviction_total", out_word_o.eviction_total, want.eviction_total);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (psel && penable && pready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    stim_row_t directed_rows [$];
    logic [ADDR_W-1:0] block_pool [$];
    access_t word;
    int sb, bb, span, pool_size, goal, phase;

    for (int i = 0; i < LINES; i++) begin
      line_live[i] = 1'b0;
      line_age[i] = '0;
      line_tags[i] = '0;
    end
    hits_so_far = '0;
    misses_so_far = '0;
    evictions_so_far = '0;
    set_bits_reg = 3'd1;
    ways_reg = 4'd1;
    block_bits_reg = 6'd1;

    // default setup: one way, set index is address bit 1
    directed_rows.push_back(typed_row(OP_LOAD, 64'h0, 1'b0, 1'b0, 0, 1, 0));
    directed_rows.push_back(typed_row(OP_LOAD, 64'h0, 1'b1, 1'b0, 1, 1, 0));
    directed_rows.push_back(typed_row(OP_STORE, 64'h4, 1'b0, 1'b1, 1, 2, 1));
    directed_rows.push_back(access_row(OP_FETCH, '1));
    directed_rows.push_back(access_row(OP_MODIFY, '1));
    directed_rows.push_back(typed_row(OP_LOAD, '1, 1'b1, 1'b0, 3, 3, 1));
    directed_rows.push_back(access_row(OP_MODIFY, 64'h4));
    // widest setup, set bits over range
    directed_rows.push_back(config_row(REG_WAYS_IN_USE, 8));
    directed_rows.push_back(config_row(REG_SET_BITS, 7));
    directed_rows.push_back(config_row(REG_BLOCK_BITS, 32));
    for (int t = 0; t < 10; t++) directed_rows.push_back(access_row(OP_LOAD, 64'(t) << 38));
    // fewer ways while lines beyond them stay valid
    directed_rows.push_back(config_row(REG_WAYS_IN_USE, 2));
    directed_rows.push_back(access_row(OP_LOAD, 64'd5 << 38));
    directed_rows.push_back(access_row(OP_STORE, 64'd9 << 38));
    // zero registers saturate up
    directed_rows.push_back(config_row(REG_SET_BITS, 0));
    directed_rows.push_back(config_row(REG_BLOCK_BITS, 0));
    directed_rows.push_back(config_row(REG_WAYS_IN_USE, 0));
    directed_rows.push_back(access_row(OP_LOAD, 64'h0));
    directed_rows.push_back(access_row(OP_STORE, '1));
    directed_rows.push_back(access_row(OP_MODIFY, 64'h8000_0000_0000_0000));
    // over-range registers saturate down
    directed_rows.push_back(config_row(REG_BLOCK_BITS, 63));
    directed_rows.push_back(config_row(REG_WAYS_IN_USE, 15));
    directed_rows.push_back(access_row(OP_LOAD, 64'hffff_ffff_0000_0000));
    directed_rows.push_back(access_row(OP_FETCH, 64'h0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        settle_block();
        set_register(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      end else begin
        send_access(directed_rows[i].word);
        if (directed_rows[i].typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back(directed_rows[i].expected);
        end
      end
    end

    phase = 0;
    while (accesses_done < ITEM_TARGET) begin
      settle_block();
      if (phase == 0) begin
        set_register(REG_SET_BITS, 1);
        set_register(REG_WAYS_IN_USE, 1);
        set_register(REG_BLOCK_BITS, 1);
      end else if (phase == 1) begin
        set_register(REG_SET_BITS, SET_BITS_MAX);
        set_register(REG_WAYS_IN_USE, DEF_MAX_WAYS);
        set_register(REG_BLOCK_BITS, BB_MAX);
      end else if ($urandom_range(0, 1) == 0) begin
        set_register(REG_SET_BITS, $urandom_range(1, SET_BITS_MAX));
        set_register(REG_WAYS_IN_USE, $urandom_range(1, DEF_MAX_WAYS));
        set_register(REG_BLOCK_BITS, $urandom_range(1, BB_MAX));
      end else begin
        set_register(REG_SET_BITS, $urandom_range(0, 7));
        set_register(REG_WAYS_IN_USE, $urandom_range(0, 15));
        set_register(REG_BLOCK_BITS, $urandom_range(0, 63));
      end
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);

      // working set of blocks crowded into a few sets
      sb = used_set_bits();
      bb = used_block_bits();
      span = (sb >= 2) ? 3 : 1;
      pool_size = $urandom_range(2, 5 * used_ways() + 2);
      block_pool.delete();
      for (int k = 0; k < pool_size; k++) begin
        block_pool.push_back(({$urandom, $urandom} << (bb + sb)) |
                             (ADDR_W'($urandom_range(0, span)) << bb));
      end

      goal = accesses_done + $urandom_range(100, 170);
      while (accesses_done < goal && accesses_done < ITEM_TARGET) begin
        if (accesses_done >= ITEM_TARGET - 150) calm_tail = 1'b1;
        word.op = op_e'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) begin
          word.address = {$urandom, $urandom};
        end else begin
          word.address = block_pool[$urandom_range(0, block_pool.size() - 1)] |
                         ({$urandom, $urandom} & ((64'd1 << bb) - 64'd1));
        end
        send_access(word);
      end
      phase++;
    end

    settle_block();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lrusac_pkg.sv
rtl/lrusac_cfg_regs.sv
rtl/lrusac_line_store.sv
rtl/lrusac_seq.sv
rtl/lru_set_associative_cache_model.sv
test/testbench.sv
